// File: rtl/wildcard_star_matcher_assert.svh
// assertion macros for the wildcard star matcher
`ifndef WILDCARD_STAR_MATCHER_ASSERT_SVH
`define WILDCARD_STAR_MATCHER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define WSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define WSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wsm_pkg.sv
// shared types and constants for the wildcard star matcher
`default_nettype none

package wsm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam logic [7:0] STAR_CHAR = 8'h2A;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_NAME   = 2'd2,
        ACT_END    = 2'd3
    } wsm_action_t;

    // command broadcast to every cell for one accepted word
    typedef struct packed {
        logic       append;
        logic       consume;
        logic       rearm;
        logic       clear;
        logic [7:0] symbol;
    } wsm_cmd_t;

    // signals handed from one cell to its right neighbor
    typedef struct packed {
        logic filled;
        logic hand;
        logic carry;
    } wsm_link_t;

endpackage

`default_nettype wire

// File: rtl/wsm_cell.sv
// one pattern position: stored character, fill flag and prefix-active bit
`default_nettype none

module wsm_cell #(
    parameter logic ACT_RESET = 1'b0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire wsm_pkg::wsm_cmd_t  cmd,
    input  wire wsm_pkg::wsm_link_t link_in,
    output wsm_pkg::wsm_link_t      link_out,
    output logic                 act,
    output logic                 tap
);

    logic       valid_reg;
    logic       act_reg;
    logic [7:0] char_reg;
    logic       star_reg;

    logic wr;
    logic v_eff;
    logic v_use;
    logic star_eff;
    logic raw;
    logic act_next;

    // the write lands on the first empty cell
    assign wr       = cmd.append & link_in.filled & ~valid_reg;
    assign v_eff    = valid_reg | wr;
    assign v_use    = v_eff & ~cmd.clear;
    assign star_eff = wr ? (cmd.symbol == wsm_pkg::STAR_CHAR) : star_reg;

    // a star keeps its own prefix alive while consuming
    assign raw      = (cmd.consume & act_reg & star_eff & v_eff) | link_in.hand;
    assign act_next = raw | link_in.carry;

    assign link_out.carry  = act_next & star_eff & v_use;
    assign link_out.hand   = cmd.consume & act_reg & valid_reg &
                             (star_reg | (char_reg == cmd.symbol));
    assign link_out.filled = valid_reg;

    assign act = act_reg;
    assign tap = act_reg & link_in.filled & ~valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            act_reg   <= ACT_RESET;
        end else begin
            if (cmd.clear) begin
                valid_reg <= 1'b0;
            end else if (wr) begin
                valid_reg <= 1'b1;
            end
            if (cmd.consume | cmd.rearm) begin
                act_reg <= act_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            char_reg <= cmd.symbol;
            star_reg <= (cmd.symbol == wsm_pkg::STAR_CHAR);
        end
    end

endmodule

`default_nettype wire

// File: rtl/wildcard_star_matcher.sv
// top level of the streaming wildcard star matcher: cell chain and result register
//
//  channel | ports                                   | carries
//  --------+-----------------------------------------+------------------------------
//  s_      | s_valid s_ready s_action s_symbol       | pattern and name words in
//  m_      | m_valid m_ready m_matched               | one result word per
//          | m_pattern_overflow                      | end of name
//
// a new word can be accepted each cycle while s_ready is high
// the star closure ripples combinationally through the cell chain as each word is accepted
// reset empties the pattern and leaves only the empty prefix active
// s_ready drops only while a result waits and m_ready is low
// result appears the cycle after the end-of-name word is accepted
`default_nettype none

module wildcard_star_matcher #(
    parameter int MAX_PATTERN = wsm_pkg::MAX_PATTERN_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [1:0]  s_action,
    input  wire [7:0]  s_symbol,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);

    `include "wildcard_star_matcher_assert.svh"

    wsm_pkg::wsm_action_t action;
    wsm_pkg::wsm_cmd_t    cmd;
    wsm_pkg::wsm_link_t   links [MAX_PATTERN+1];

    logic [MAX_PATTERN:0] act_vec;
    logic [MAX_PATTERN:0] tap_vec;

    logic accept;
    logic out_free;
    logic hit;

    // final prefix bit: whole pattern consumed
    logic last_act_reg;
    logic last_act_next;
    logic ovf_reg;

    logic m_valid_reg;
    logic m_matched_reg;
    logic m_ovf_reg;

    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = out_free;
    assign accept   = s_valid & s_ready;
    assign action   = wsm_pkg::wsm_action_t'(s_action);

    // decode the word into the broadcast command
    always_comb begin
        cmd.append  = 1'b0;
        cmd.consume = 1'b0;
        cmd.rearm   = 1'b0;
        cmd.clear   = 1'b0;
        cmd.symbol  = s_symbol;
        if (accept) begin
            unique case (action)
                wsm_pkg::ACT_CLEAR: begin
                    cmd.clear = 1'b1;
                    cmd.rearm = 1'b1;
                end
                wsm_pkg::ACT_APPEND: begin
                    cmd.append = 1'b1;
                    cmd.rearm  = 1'b1;
                end
                wsm_pkg::ACT_NAME: begin
                    cmd.consume = 1'b1;
                end
                wsm_pkg::ACT_END: begin
                    cmd.rearm = 1'b1;
                end
                default: begin
                    cmd.rearm = 1'b0;
                end
            endcase
        end
    end

    // head of the chain: always filled, seeds the empty prefix on rearm
    assign links[0].filled = 1'b1;
    assign links[0].hand   = cmd.rearm;
    assign links[0].carry  = 1'b0;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        wsm_cell #(
            .ACT_RESET ((i == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .act      (act_vec[i]),
            .tap      (tap_vec[i])
        );
    end

    // tail position, active only when every cell is filled
    assign last_act_next      = links[MAX_PATTERN].hand | links[MAX_PATTERN].carry;
    assign act_vec[MAX_PATTERN] = last_act_reg;
    assign tap_vec[MAX_PATTERN] = last_act_reg & links[MAX_PATTERN].filled;

    // prefix active at exactly the pattern length
    assign hit = |tap_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_act_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.consume | cmd.rearm) begin
                last_act_reg <= last_act_next;
            end
            // append into a full store drops the char and flags it
            if (cmd.clear) begin
                ovf_reg <= 1'b0;
            end else if (cmd.append & links[MAX_PATTERN].filled) begin
                ovf_reg <= 1'b1;
            end
            if (accept && action == wsm_pkg::ACT_END) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with the end-of-name word
    always_ff @(posedge aclk) begin
        if (accept && action == wsm_pkg::ACT_END) begin
            m_matched_reg <= hit & ~ovf_reg;
            m_ovf_reg     <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_ovf_reg;

    `WSM_ASSERT_NOW(a_ovf_no_match, m_valid && m_pattern_overflow, !m_matched,
        "overflow result reports a match")
    `WSM_ASSERT_NEXT(a_end_gives_result, s_valid && s_ready && s_action == wsm_pkg::ACT_END,
        m_valid, "end of name produced no result")
    `WSM_ASSERT_NEXT(a_clear_rearms, s_valid && s_ready && s_action == wsm_pkg::ACT_CLEAR,
        act_vec == (MAX_PATTERN+1)'(1) && !ovf_reg, "clear did not rearm")
    `WSM_ASSERT_NOW(a_one_end_tap, 1'b1, $onehot0(tap_vec),
        "more than one pattern end position")

endmodule

`default_nettype wire

// File: tb/wsm_checker.sv
// checker for the wildcard star matcher: predicts each end-of-name verdict and compares it
`default_nettype none

module wsm_checker #(
    parameter int MAX_PATTERN = wsm_pkg::MAX_PATTERN_DEF
) (
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    input  wire       s_ready,
    input  wire [1:0] s_action,
    input  wire [7:0] s_symbol,
    input  wire       m_valid,
    input  wire       m_ready,
    input  wire       m_matched,
    input  wire       m_pattern_overflow,
    output int        mismatches,
    output int        outstanding
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    verdict_t             verdicts_due[$];
    verdict_t             oldest;
    logic [7:0]           glob_bytes [MAX_PATTERN];
    int                   glob_len;
    logic [MAX_PATTERN:0] live_prefixes;
    logic                 glob_overflowed;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // extend every live prefix across a star that follows it
    function automatic logic [MAX_PATTERN:0] close_stars(input logic [MAX_PATTERN:0] v);
        for (int i = 0; i < glob_len; i++) begin
            if (v[i] && glob_bytes[i] == wsm_pkg::STAR_CHAR)
                v[i+1] = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [MAX_PATTERN:0] advance_prefixes(input logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int i = 0; i < glob_len; i++) begin
            if (live_prefixes[i]) begin
                if (glob_bytes[i] == wsm_pkg::STAR_CHAR) begin
                    nxt[i]   = 1'b1;
                    nxt[i+1] = 1'b1;
                end else if (glob_bytes[i] == c) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return close_stars(nxt);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            glob_len        = 0;
            glob_overflowed = 1'b0;
            live_prefixes   = close_stars({{MAX_PATTERN{1'b0}}, 1'b1});
            verdicts_due.delete();
        end else begin
            // result side first: it always belongs to an earlier word
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result word with no end of name pending");
                end else begin
                    oldest = verdicts_due.pop_front();
                    if (m_matched !== oldest.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                            m_matched, oldest.matched));
                    if (m_pattern_overflow !== oldest.overflow)
                        report_mismatch($sformatf("pattern_overflow %b, expected %b",
                            m_pattern_overflow, oldest.overflow));
                end
            end
            if (s_valid && s_ready) begin
                case (wsm_pkg::wsm_action_t'(s_action))
                    wsm_pkg::ACT_CLEAR: begin
                        glob_len        = 0;
                        glob_overflowed = 1'b0;
                        live_prefixes   = close_stars({{MAX_PATTERN{1'b0}}, 1'b1});
                    end
                    wsm_pkg::ACT_APPEND: begin
                        if (glob_len < MAX_PATTERN) begin
                            glob_bytes[glob_len] = s_symbol;
                            glob_len++;
                        end else begin
                            glob_overflowed = 1'b1;
                        end
                        live_prefixes = close_stars({{MAX_PATTERN{1'b0}}, 1'b1});
                    end
                    wsm_pkg::ACT_NAME: begin
                        live_prefixes = advance_prefixes(s_symbol);
                    end
                    default: begin
                        verdicts_due.push_back('{
                            matched:  !glob_overflowed && live_prefixes[glob_len],
                            overflow: glob_overflowed});
                        live_prefixes = close_stars({{MAX_PATTERN{1'b0}}, 1'b1});
                    end
                endcase
            end
        end
        outstanding = verdicts_due.size();
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench top for the wildcard star matcher: stimulus, receiver stalls and verdict
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int WORD_TARGET = 1400;
    // word count at which the receiver takes its long break
    localparam int LONG_HOLD_AT = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h00;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    wsm_pkg::wsm_action_t s_action;
    logic [7:0]           s_symbol;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_matched;
    logic                 m_pattern_overflow;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int words_sent = 0;
    bit sender_steady = 1'b0;
    bit long_hold_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    wildcard_star_matcher i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_symbol           (s_symbol),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    wsm_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_symbol           (s_symbol),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // character mix: plenty of stars and a tiny alphabet so names match often
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return wsm_pkg::STAR_CHAR;
        if (roll < 45) return CH_A;
        if (roll < 60) return CH_B;
        if (roll < 70) return CH_QUERY;
        if (roll < 78) return CH_ZERO;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one word after a random gap (none while steady), hold it until accepted
    task automatic send_word(input wsm_pkg::wsm_action_t act, input logic [7:0] sym);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_symbol <= sym;
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_sent++;
    endtask

    // receiver: random stall per result word, steady stretches, one long hold-off
    initial begin : result_drain
        int hold;
        int steady_left;
        steady_left = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!long_hold_done && words_sent >= LONG_HOLD_AT) begin
                // sender keeps offering, so the result register fills and s_ready drops
                long_hold_done = 1'b1;
                hold = LONG_HOLD_CYCLES;
            end else if (steady_left > 0) begin
                steady_left--;
                hold = 0;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    steady_left = 20;
                hold = $urandom_range(0, 15);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        logic [7:0] glob[$];
        logic [7:0] name_text[$];
        logic [7:0] c;
        int plen;
        int roll;
        int names;

        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_action <= wsm_pkg::ACT_CLEAR;
        s_symbol <= 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pattern takes only the empty name
        send_word(wsm_pkg::ACT_END, 8'hA5);
        send_word(wsm_pkg::ACT_NAME, CH_A);
        send_word(wsm_pkg::ACT_END, 8'h00);
        // lone star matches empty and arbitrary names, extreme bytes included
        send_word(wsm_pkg::ACT_APPEND, wsm_pkg::STAR_CHAR);
        send_word(wsm_pkg::ACT_END, 8'hFF);
        send_word(wsm_pkg::ACT_NAME, 8'hFF);
        send_word(wsm_pkg::ACT_NAME, CH_ZERO);
        send_word(wsm_pkg::ACT_END, 8'h5A);
        // zero byte in the pattern is a literal
        send_word(wsm_pkg::ACT_CLEAR, 8'hFF);
        send_word(wsm_pkg::ACT_APPEND, CH_A);
        send_word(wsm_pkg::ACT_APPEND, wsm_pkg::STAR_CHAR);
        send_word(wsm_pkg::ACT_APPEND, CH_ZERO);
        send_word(wsm_pkg::ACT_NAME, CH_A);
        send_word(wsm_pkg::ACT_NAME, 8'h78);
        send_word(wsm_pkg::ACT_NAME, CH_ZERO);
        send_word(wsm_pkg::ACT_END, 8'h00);
        // append in the middle of a name restarts matching against the longer pattern
        send_word(wsm_pkg::ACT_NAME, CH_A);
        send_word(wsm_pkg::ACT_APPEND, CH_QUERY);
        send_word(wsm_pkg::ACT_NAME, CH_A);
        send_word(wsm_pkg::ACT_NAME, CH_ZERO);
        send_word(wsm_pkg::ACT_NAME, CH_QUERY);
        send_word(wsm_pkg::ACT_END, 8'h33);
        // question mark is literal, no match against another byte
        send_word(wsm_pkg::ACT_CLEAR, 8'h00);
        send_word(wsm_pkg::ACT_APPEND, CH_QUERY);
        send_word(wsm_pkg::ACT_NAME, 8'hFE);
        send_word(wsm_pkg::ACT_END, 8'hCC);

        // random part: mostly clean pattern/name sequences, some noise
        while (words_sent < WORD_TARGET) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85) begin
                glob.delete();
                roll = $urandom_range(0, 99);
                // lengths past the store reach the overflow case
                plen = (roll < 90) ? $urandom_range(0, 8) :
                       (roll < 97) ? $urandom_range(9, 32) : $urandom_range(33, 36);
                send_word(wsm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
                for (int k = 0; k < plen; k++) begin
                    c = pick_char();
                    glob.push_back(c);
                    send_word(wsm_pkg::ACT_APPEND, c);
                end
                names = $urandom_range(1, 4);
                repeat (names) begin
                    // build a name from the pattern: stars expand to 0..3 fillers
                    name_text.delete();
                    foreach (glob[j]) begin
                        if (glob[j] == wsm_pkg::STAR_CHAR) begin
                            repeat ($urandom_range(0, 3)) name_text.push_back(pick_char());
                        end else begin
                            name_text.push_back(glob[j]);
                        end
                    end
                    // spoil some names so misses show up too
                    roll = $urandom_range(0, 99);
                    if (roll < 15 && name_text.size() > 0)
                        name_text[$urandom_range(0, name_text.size() - 1)] = pick_char();
                    else if (roll < 25)
                        name_text.push_back(pick_char());
                    else if (roll < 32 && name_text.size() > 0)
                        name_text.delete($urandom_range(0, name_text.size() - 1));
                    foreach (name_text[j]) begin
                        send_word(wsm_pkg::ACT_NAME, name_text[j]);
                        if ($urandom_range(0, 99) == 0) begin
                            c = pick_char();
                            glob.push_back(c);
                            send_word(wsm_pkg::ACT_APPEND, c);
                        end
                    end
                    send_word(wsm_pkg::ACT_END, 8'($urandom_range(0, 255)));
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(wsm_pkg::wsm_action_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
            end
        end
        s_valid <= 1'b0;

        // let the checker see the last word, drain, then idle before the verdict
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
